// ===== rtl/rcpf_pkg.sv =====
// ----------------------------------------------------------------------------
// rcpf_pkg: shared types and constants of the command packet framer
// Holds the job record passed from the front end to the back end through the
// queue, the sync bytes, the register indexes and the reset values.
// ----------------------------------------------------------------------------
package rcpf_pkg;

  localparam logic [7:0] SYNC_FIRST    = 8'hFA;
  localparam logic [7:0] SYNC_SECOND   = 8'hFB;
  localparam logic [7:0] COUNT_EXTRA   = 8'd5;
  localparam logic [7:0] MAX_PAYLOAD   = 8'd247;
  localparam logic [7:0] CMD_RESET     = 8'h64;
  localparam logic [7:0] ARG_RESET     = 8'h2B;

  // register indexes on the configuration port
  localparam logic REG_COMMAND_CODE  = 1'b0;
  localparam logic REG_ARGUMENT_TYPE = 1'b1;

  localparam int QUEUE_DEPTH = 4;

  // one accepted input beat, classified and with its checksum settled
  typedef struct packed {
    logic        hdr;       // first beat of a packet: header goes out first
    logic        has_data;  // a payload byte goes out
    logic        closing;   // checksum follows
    logic [7:0]  len;       // saturated payload length
    logic [7:0]  cmd;
    logic [7:0]  typ;
    logic [7:0]  data;
    logic [15:0] csum;      // final checksum, valid when closing
  } job_t;

endpackage

// ===== rtl/rcpf_front.sv =====
// ----------------------------------------------------------------------------
// rcpf_front: input side of the framer
// Holds the configuration registers and the packet state, classifies each
// input beat and folds it into the running checksum.
// ----------------------------------------------------------------------------
module rcpf_front
  import rcpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  packet_length,
  input  logic        accept,
  output job_t        job
);

  logic        in_packet;
  logic [7:0]  bytes_left;
  logic [15:0] checksum_sum;
  logic [7:0]  held_high_byte;
  logic        byte_is_held;
  logic [7:0]  command_code;
  logic [7:0]  argument_type;

  logic [7:0]  len_sat;
  logic        hdr;
  logic        has_data;
  logic [15:0] sum_base;
  logic [7:0]  held_base;
  logic        hv_base;
  logic [7:0]  left_base;
  logic [15:0] checksum_sum_next;
  logic [7:0]  held_high_byte_next;
  logic        byte_is_held_next;
  logic [7:0]  bytes_left_next;
  logic        closing;

  always_comb begin
    len_sat = (packet_length > MAX_PAYLOAD) ? MAX_PAYLOAD : packet_length;
    hdr     = !in_packet;
    if (hdr) begin
      // command and type form the first pair, length waits for a partner
      sum_base  = {command_code, argument_type};
      held_base = len_sat;
      hv_base   = 1'b1;
      left_base = len_sat;
    end else begin
      sum_base  = checksum_sum;
      held_base = held_high_byte;
      hv_base   = byte_is_held;
      left_base = bytes_left;
    end
    has_data = !hdr || (len_sat != 8'd0);
    if (has_data) begin
      if (hv_base) begin
        checksum_sum_next   = sum_base + {held_base, data_byte};
        held_high_byte_next = 8'd0;
        byte_is_held_next   = 1'b0;
      end else begin
        checksum_sum_next   = sum_base;
        held_high_byte_next = data_byte;
        byte_is_held_next   = 1'b1;
      end
      bytes_left_next = (left_base != 8'd0) ? left_base - 8'd1 : 8'd0;
    end else begin
      checksum_sum_next   = sum_base;
      held_high_byte_next = held_base;
      byte_is_held_next   = hv_base;
      bytes_left_next     = 8'd0;
    end
    closing = (bytes_left_next == 8'd0);

    job.hdr      = hdr;
    job.has_data = has_data;
    job.closing  = closing;
    job.len      = len_sat;
    job.cmd      = command_code;
    job.typ      = argument_type;
    job.data     = data_byte;
    // odd byte count: the unpaired byte is XORed in
    job.csum     = checksum_sum_next ^
                   (byte_is_held_next ? {8'd0, held_high_byte_next} : 16'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet      <= 1'b0;
      bytes_left     <= 8'd0;
      checksum_sum   <= 16'd0;
      held_high_byte <= 8'd0;
      byte_is_held   <= 1'b0;
      command_code   <= CMD_RESET;
      argument_type  <= ARG_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_COMMAND_CODE:  command_code  <= cfg_data;
          REG_ARGUMENT_TYPE: argument_type <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && accept) begin
        if (closing) begin
          in_packet      <= 1'b0;
          bytes_left     <= 8'd0;
          checksum_sum   <= 16'd0;
          held_high_byte <= 8'd0;
          byte_is_held   <= 1'b0;
        end else begin
          in_packet      <= 1'b1;
          bytes_left     <= bytes_left_next;
          checksum_sum   <= checksum_sum_next;
          held_high_byte <= held_high_byte_next;
          byte_is_held   <= byte_is_held_next;
        end
      end
    end
  end

endmodule

// ===== rtl/rcpf_queue.sv =====
// ----------------------------------------------------------------------------
// rcpf_queue: short job queue between front and back end
// Register-based FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module rcpf_queue
  import rcpf_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
)
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign empty = (count == CntW'(0));
  assign full  = (count == CntW'(Depth));
  assign head  = mem[rd_ptr];

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? PtrW'(0) : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/rcpf_back.sv =====
// ----------------------------------------------------------------------------
// rcpf_back: output side of the framer
// Expands each queued job into its wire bytes (header, payload, checksum)
// into a registered output stage.
// ----------------------------------------------------------------------------
module rcpf_back
  import rcpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  job_t       job,
  input  logic       empty,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast,
  output logic       m_tuser
);

  typedef enum logic [3:0] {
    B_SYNC1, B_SYNC2, B_COUNT, B_CMD, B_TYPE, B_LEN, B_DATA, B_CSUM_HI, B_CSUM_LO
  } beat_t;

  beat_t pos;
  logic  mid;   // part of the head job already sent, pos is valid

  beat_t      cur;
  beat_t      nxt;
  logic       done;
  logic       fire;
  logic [7:0] byte_val;

  always_comb begin
    if (mid) begin
      cur = pos;
    end else if (job.hdr) begin
      cur = B_SYNC1;
    end else if (job.has_data) begin
      cur = B_DATA;
    end else begin
      cur = B_CSUM_HI;
    end

    nxt  = B_SYNC1;
    done = 1'b0;
    case (cur)
      B_SYNC1:   nxt = B_SYNC2;
      B_SYNC2:   nxt = B_COUNT;
      B_COUNT:   nxt = B_CMD;
      B_CMD:     nxt = B_TYPE;
      B_TYPE:    nxt = B_LEN;
      B_LEN: begin
        if (job.has_data) begin
          nxt = B_DATA;
        end else begin
          nxt = B_CSUM_HI;
        end
      end
      B_DATA: begin
        nxt  = B_CSUM_HI;
        done = !job.closing;
      end
      B_CSUM_HI: nxt = B_CSUM_LO;
      B_CSUM_LO: done = 1'b1;
      default:   done = 1'b1;
    endcase

    case (cur)
      B_SYNC1:   byte_val = SYNC_FIRST;
      B_SYNC2:   byte_val = SYNC_SECOND;
      B_COUNT:   byte_val = job.len + COUNT_EXTRA;
      B_CMD:     byte_val = job.cmd;
      B_TYPE:    byte_val = job.typ;
      B_LEN:     byte_val = job.len;
      B_DATA:    byte_val = job.data;
      B_CSUM_HI: byte_val = job.csum[15:8];
      B_CSUM_LO: byte_val = job.csum[7:0];
      default:   byte_val = 8'd0;
    endcase
  end

  assign fire = !empty && (!m_tvalid || m_tready);
  assign pop  = fire && done;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      mid      <= 1'b0;
      pos      <= B_SYNC1;
    end else begin
      if (fire) begin
        m_tvalid <= 1'b1;
        mid      <= !done;
        pos      <= nxt;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= byte_val;
      m_tlast <= (cur == B_CSUM_LO);
      m_tuser <= done;
    end
  end

endmodule

// ===== rtl/robot_command_packet_framer.sv =====
// ----------------------------------------------------------------------------
// robot_command_packet_framer: serial command packet framer
// Wraps a stream of payload bytes into sync/count/header/checksum packets.
// ----------------------------------------------------------------------------
//  - Slave stream s_*: one beat per payload byte; the first beat of a packet
//    also carries the payload length (saturated to 247). A zero-length packet
//    is a single beat whose data byte is ignored.
//  - Master stream m_*: 0xFA 0xFB, length+5, command, argument type, length,
//    payload, checksum high, checksum low. tlast marks the low checksum byte,
//    tuser the last byte caused by an input beat.
//  - Config port: index 0 command code, index 1 argument type; write idle.
//  - Checksum: big-endian byte pairs over command..payload summed mod 2^16,
//    an odd trailing byte is XORed in.
//  - An input beat is written into the job queue; its first byte then goes out through the output register.
//  - Throughput: one byte per cycle through the output register while a job is queued and the receiver
//    takes it; a payload beat yields 1 byte, a first beat 7 (8 if empty, 9 if also last), a last beat 3.
//  - A four-entry job queue lets the input run on while the receiver stalls,
//    until it fills and s_tready drops.
//  - Reset (rst, synchronous) empties the queue, drops any open packet and
//    restores command 0x64 and argument type 0x2B.
// ----------------------------------------------------------------------------
module robot_command_packet_framer
  import rcpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] data_byte, [15:8] packet_length
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,   // end_of_packet
  output logic        m_tuser    // [0] last_of_run
);

  job_t front_job;
  job_t head_job;
  logic q_empty;
  logic q_full;
  logic q_pop;

  // input beat goes in whenever the queue has room
  assign s_tready = !q_full;

  rcpf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (s_tvalid),
    .data_byte     (s_tdata[7:0]),
    .packet_length (s_tdata[15:8]),
    .accept        (s_tready),
    .job           (front_job)
  );

  rcpf_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (s_tvalid && s_tready),
    .push_job (front_job),
    .pop      (q_pop),
    .head     (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  rcpf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job      (head_job),
    .empty    (q_empty),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
